FILE: sv/dlrq_pkg.sv
// Package of shared types, constants and ring-pointer helpers for the delay/loss release queue.
package dlrq_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int MAX_RESULTS = 32;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W       = CNT_W + 1;
  localparam int K_W         = $clog2(MAX_RESULTS + 1);
  localparam int REM_W       = 25;
  localparam int FLOW_W      = 16;
  localparam int TIME_W      = 24;
  localparam int TICK_W      = 20;
  localparam int CNT32_W     = 32;
  localparam int RAND_W      = 16;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [1:0] {
    KIND_ACCEPT  = 2'd0,
    KIND_FULL    = 2'd1,
    KIND_RELEASE = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  typedef enum logic {
    CMD_ENQUEUE = 1'b0,
    CMD_TICK    = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [FLOW_W-1:0]  flow_id;
    logic               flow_known;
    logic [TIME_W-1:0]  mean_delay_us;
    logic [TIME_W-1:0]  jitter_us;
    logic [CNT32_W-1:0] loss_count;
    logic [CNT32_W-1:0] tx_count;
    logic [RAND_W-1:0]  rand_delay;
    logic [RAND_W-1:0]  rand_loss;
    logic [TICK_W-1:0]  tick_us;
  } req_t;

  typedef struct packed {
    kind_t             kind;
    logic [FLOW_W-1:0] released_flow_id;
    logic              last;
  } rsp_t;

  typedef struct packed {
    logic [FLOW_W-1:0] flow;
    logic [REM_W-1:0]  remain;
    logic              lost;
  } entry_t;

  typedef struct packed {
    logic [REM_W-1:0] delay;
    logic             lost;
  } enq_res_t;

  // ring position base + cnt, cnt below the depth
  function automatic ptr_t ptr_add(input ptr_t base, input cnt_t cnt);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(cnt);
    if (sum >= SUM_W'(QUEUE_DEPTH)) begin
      sum = sum - SUM_W'(QUEUE_DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  function automatic ptr_t ptr_inc(input ptr_t p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic ptr_t ptr_dec(input ptr_t p);
    return (p == '0) ? PTR_W'(QUEUE_DEPTH - 1) : p - PTR_W'(1);
  endfunction

endpackage

FILE: sv/dlrq_enq_calc.sv
// Delay and loss-mark arithmetic for an enqueued command, products registered.
module dlrq_enq_calc import dlrq_pkg::*; (
  input  logic     clk,
  input  req_t     item,
  output enq_res_t res
);

  localparam int SPAN_P_W = RAND_W + TIME_W + 1;
  localparam int LOSS_P_W = RAND_W + CNT32_W;
  localparam int ADD_W    = REM_W + 1;

  logic [SPAN_P_W-1:0] span_prod;
  logic [LOSS_P_W-1:0] loss_prod;
  logic [CNT32_W-1:0]  tx_eff;
  logic [REM_W-1:0]    span;
  logic [ADD_W-1:0]    mean_span;
  logic [ADD_W-1:0]    diff;
  logic [LOSS_P_W-1:0] loss_rhs;

  // transmit count treated as at least one
  assign tx_eff = (item.tx_count == '0) ? CNT32_W'(1) : item.tx_count;

  always_ff @(posedge clk) begin
    span_prod <= SPAN_P_W'(item.rand_delay) * SPAN_P_W'({item.jitter_us, 1'b0});
    loss_prod <= LOSS_P_W'(item.rand_loss) * LOSS_P_W'(tx_eff);
  end

  assign span      = span_prod[SPAN_P_W-1:RAND_W];
  assign mean_span = ADD_W'(item.mean_delay_us) + ADD_W'(span);
  assign diff      = mean_span - ADD_W'(item.jitter_us);
  assign loss_rhs  = {item.loss_count, {RAND_W{1'b0}}};

  always_comb begin
    res = '0;
    if (item.flow_known) begin
      // clamp at zero
      res.delay = (mean_span < ADD_W'(item.jitter_us)) ? '0 : diff[REM_W-1:0];
      res.lost  = (loss_prod < loss_rhs);
    end
  end

endmodule

FILE: sv/delay_loss_release_queue.sv
// Top level of the delay/loss release queue: command sequencer around the entry memory.
//
// Usage. A word is offered on req and taken at the rising edge where start is
// high and busy is low. Every result word appears on rsp for exactly one cycle
// with strobe high; the receiver cannot stall, so no result is ever held back.
// The final result of an item carries last.
//
// Enqueue: the flow's delay and loss mark are worked out and the command is
// stored at the newest end of a ring in one memory. An accepted command passes
// ENQ_MUL and ENQ_WR before its strobe (kind 0); on a full queue the strobe
// comes in the cycle after acceptance (kind 1). An accepted command is written before a new word is taken.
//
// Tick: the ring is walked from newest to oldest, one memory read per cycle,
// with the read data used in the following cycle. Survivors are written back
// packed against the newest end, so order is kept and the ring base moves up.
// Each release is held in a pending register until the next one is found, so
// that the last one can carry last; a tick with no release answers kind 3.
// Busy holds until the ring is read through the single read port of the
// entry memory and the final word given, at once for an empty ring.
//
// Reset clears the count, ring base and control state, not the memory; its
// contents are never read before being written, so no clearing pass is run.
module delay_loss_release_queue import dlrq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t req,
  output logic strobe,
  output rsp_t rsp
);

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_ENQ_MUL = 5'b00010,
    ST_ENQ_WR  = 5'b00100,
    ST_WALK    = 5'b01000,
    ST_FINISH  = 5'b10000
  } state_t;

  state_t state, state_next;
  req_t   item, item_next;
  ptr_t   base, base_next;
  cnt_t   count, count_next;
  cnt_t   rd_left, rd_left_next;
  ptr_t   rp, rp_next;
  ptr_t   wp, wp_next;
  logic   pv, pv_next;
  cnt_t   sv, sv_next;
  logic [K_W-1:0] k, k_next;
  logic   pend_valid, pend_valid_next;
  logic [FLOW_W-1:0] pend_flow, pend_flow_next;
  logic   strobe_next;
  rsp_t   rsp_next;

  // entry memory
  entry_t mem [QUEUE_DEPTH];
  entry_t rdata;
  logic   ren, we;
  ptr_t   raddr, waddr;
  entry_t wdata;

  enq_res_t enq_res;
  ptr_t     newest;

  dlrq_enq_calc u_calc (
    .clk  (clk),
    .item (item),
    .res  (enq_res)
  );

  assign busy   = (state != ST_IDLE);
  assign newest = ptr_add(base, count - CNT_W'(1));

  always_ff @(posedge clk) begin
    if (ren) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_comb begin
    state_next      = state;
    item_next       = item;
    base_next       = base;
    count_next      = count;
    rd_left_next    = rd_left;
    rp_next         = rp;
    wp_next         = wp;
    pv_next         = 1'b0;
    sv_next         = sv;
    k_next          = k;
    pend_valid_next = pend_valid;
    pend_flow_next  = pend_flow;
    strobe_next     = 1'b0;
    rsp_next        = rsp;
    ren             = 1'b0;
    raddr           = rp;
    we              = 1'b0;
    waddr           = wp;
    wdata           = rdata;

    case (state)
      ST_IDLE: begin
        if (start) begin
          item_next = req;
          if (req.cmd == CMD_ENQUEUE) begin
            if (count == CNT_W'(QUEUE_DEPTH)) begin
              // full: answer at once, store nothing
              strobe_next = 1'b1;
              rsp_next    = '{kind: KIND_FULL, released_flow_id: '0, last: 1'b1};
            end else begin
              state_next = ST_ENQ_MUL;
            end
          end else begin
            rd_left_next    = count;
            rp_next         = newest;
            wp_next         = newest;
            sv_next         = '0;
            k_next          = '0;
            pend_valid_next = 1'b0;
            // an empty ring still answers with a no-release word
            state_next      = (count == '0) ? ST_FINISH : ST_WALK;
            if (count == '0) begin
              wp_next = ptr_dec(base);
            end
          end
        end
      end

      ST_ENQ_MUL: begin
        state_next = ST_ENQ_WR;
      end

      ST_ENQ_WR: begin
        we          = 1'b1;
        waddr       = ptr_add(base, count);
        wdata       = '{flow: item.flow_id, remain: enq_res.delay, lost: enq_res.lost};
        count_next  = count + CNT_W'(1);
        strobe_next = 1'b1;
        rsp_next    = '{kind: KIND_ACCEPT, released_flow_id: '0, last: 1'b1};
        state_next  = ST_IDLE;
      end

      ST_WALK: begin
        // issue the next read
        if (rd_left != '0) begin
          ren          = 1'b1;
          raddr        = rp;
          rp_next      = ptr_dec(rp);
          rd_left_next = rd_left - CNT_W'(1);
          pv_next      = 1'b1;
        end
        // handle the word read last cycle
        if (pv) begin
          if (rdata.lost) begin
            // drop silently
          end else if (rdata.remain <= REM_W'(item.tick_us)) begin
            if (k < K_W'(MAX_RESULTS)) begin
              k_next = k + K_W'(1);
              if (pend_valid) begin
                strobe_next = 1'b1;
                rsp_next    = '{kind: KIND_RELEASE, released_flow_id: pend_flow, last: 1'b0};
              end
              pend_valid_next = 1'b1;
              pend_flow_next  = rdata.flow;
            end else begin
              // result budget spent: keep it, expired
              we           = 1'b1;
              waddr        = wp;
              wdata.remain = '0;
              wp_next      = ptr_dec(wp);
              sv_next      = sv + CNT_W'(1);
            end
          end else begin
            we           = 1'b1;
            waddr        = wp;
            wdata.remain = rdata.remain - REM_W'(item.tick_us);
            wp_next      = ptr_dec(wp);
            sv_next      = sv + CNT_W'(1);
          end
        end
        // the last word is handled in the cycle its read count reaches zero
        if (rd_left == '0) begin
          state_next = ST_FINISH;
        end
      end

      ST_FINISH: begin
        // survivors sit just above the write pointer
        base_next   = ptr_inc(wp);
        count_next  = sv;
        strobe_next = 1'b1;
        if (pend_valid) begin
          rsp_next = '{kind: KIND_RELEASE, released_flow_id: pend_flow, last: 1'b1};
        end else begin
          rsp_next = '{kind: KIND_NONE, released_flow_id: '0, last: 1'b1};
        end
        pend_valid_next = 1'b0;
        state_next      = ST_IDLE;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      base       <= '0;
      count      <= '0;
      rd_left    <= '0;
      pv         <= 1'b0;
      k          <= '0;
      pend_valid <= 1'b0;
      strobe     <= 1'b0;
    end else begin
      state      <= state_next;
      base       <= base_next;
      count      <= count_next;
      rd_left    <= rd_left_next;
      pv         <= pv_next;
      k          <= k_next;
      pend_valid <= pend_valid_next;
      strobe     <= strobe_next;
    end
  end

  // payload and walk pointers
  always_ff @(posedge clk) begin
    item      <= item_next;
    rp        <= rp_next;
    wp        <= wp_next;
    sv        <= sv_next;
    pend_flow <= pend_flow_next;
    rsp       <= rsp_next;
  end

endmodule
